// ===== hw/rtl/rrws_pkg.sv =====
// Shared types, widths and codes of the row rebin weighted sum unit.
package rrws_pkg;

	localparam int MAX_SOURCE_WIDTH = 1024;
	localparam int MAX_RESULT_WIDTH = 1024;
	localparam int MAX_TAPS         = 8;

	// Field widths fixed by the item formats
	localparam int IDX_W    = 10;
	localparam int SLOT_W   = 3;
	localparam int TOTAL_W  = 4;
	localparam int WEIGHT_W = 18;
	localparam int PIXEL_W  = 24;
	localparam int VALUE_W  = 32;
	localparam int WIDTH_W  = 11;
	localparam int MODE_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	// Storage and arithmetic widths
	localparam int ROW_AW  = $clog2(MAX_SOURCE_WIDTH);
	localparam int RES_AW  = $clog2(MAX_RESULT_WIDTH);
	localparam int WT_AW   = $clog2(MAX_RESULT_WIDTH * MAX_TAPS);
	localparam int TAP_W   = $clog2(MAX_TAPS);
	localparam int CNT_W   = $clog2(MAX_TAPS + 1);
	localparam int SRC_W   = IDX_W + 2;
	localparam int PROD_W  = PIXEL_W + WEIGHT_W;
	localparam int ACC_W   = PROD_W + TAP_W;
	localparam int FRAC_W  = 16;
	localparam int Q_W     = ACC_W + 1 - FRAC_W;

	typedef enum logic [1:0] {
		OP_HEADER  = 2'd0,
		OP_WEIGHT  = 2'd1,
		OP_PIXEL   = 2'd2,
		OP_COMPUTE = 2'd3
	} op_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_PLAIN     = 2'd0,
		MODE_ZERO      = 2'd1,
		MODE_REPLICATE = 2'd2
	} edge_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_WIDTH = 3'd0,
		REG_RESULT_WIDTH = 3'd1,
		REG_EDGE_MODE    = 3'd2,
		REG_EDGE_LEFT    = 3'd3,
		REG_EDGE_RIGHT   = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HEAD,
		ST_TAPS,
		ST_DRAIN,
		ST_ROUND
	} state_t;

	typedef struct packed {
		logic [IDX_W-1:0] start;
		logic [CNT_W-1:0] count;
	} hdr_t;

endpackage

// ===== hw/rtl/rrws_req_if.sv =====
// Request channel: operation beats into the unit.
interface rrws_req_if
	import rrws_pkg::*;
();
	logic                       valid;
	logic                       ready;
	op_t                        operation;
	logic [IDX_W-1:0]           target_index;
	logic [SLOT_W-1:0]          tap_slot;
	logic [TOTAL_W-1:0]         tap_total;
	logic [IDX_W-1:0]           start_index;
	logic signed [WEIGHT_W-1:0] tap_weight;
	logic [IDX_W-1:0]           pixel_index;
	logic signed [PIXEL_W-1:0]  pixel_value;

	modport source (
		output valid, operation, target_index, tap_slot, tap_total,
		       start_index, tap_weight, pixel_index, pixel_value,
		input  ready
	);
	modport sink (
		input  valid, operation, target_index, tap_slot, tap_total,
		       start_index, tap_weight, pixel_index, pixel_value,
		output ready
	);
endinterface

// ===== hw/rtl/rrws_rsp_if.sv =====
// Response channel: result beats out of the unit.
interface rrws_rsp_if
	import rrws_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic [IDX_W-1:0]          result_index;
	logic signed [VALUE_W-1:0] result_value;
	logic                      saturated;

	modport source (
		output valid, result_index, result_value, saturated,
		input  ready
	);
	modport sink (
		input  valid, result_index, result_value, saturated,
		output ready
	);
endinterface

// ===== hw/rtl/row_rebin_weighted_sum_unit.sv =====
// Row rebin weighted sum unit: table-driven resampler of one image row.
//
//  channel  | dir | beat carries
//  ---------+-----+---------------------------------------------------------
//  req      | in  | operation, target_index, tap_slot, tap_total, start_index,
//           |     | tap_weight, pixel_index, pixel_value
//  rsp      | out | result_index, result_value, saturated (compute only)
//  cfg      | in  | cfg_wr_en, cfg_index, cfg_wdata (no wait, no read-back)
//
// Header, weight and pixel writes land in memory when accepted. A compute
// request steps through its taps one after another, set by the single read
// port of the row and weight memories feeding one shared multiply-accumulate;
// a request that lands outside the valid span or has no taps skips the tap
// pass. After reset a clearing pass zeroes all MAX_RESULT_WIDTH (1024) tap
// counts; req.ready stays low meanwhile, configuration writes still land.
// A result waits in the output register while further writes are accepted.
module row_rebin_weighted_sum_unit
	import rrws_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	rrws_req_if.sink              req,
	rrws_rsp_if.source            rsp
);

	// Configuration registers
	logic [WIDTH_W-1:0] source_width_q;
	logic [WIDTH_W-1:0] result_width_q;
	logic [MODE_W-1:0]  edge_mode_q;
	logic [IDX_W-1:0]   edge_left_q;
	logic [IDX_W-1:0]   edge_right_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q <= WIDTH_W'(1024);
			result_width_q <= WIDTH_W'(1024);
			edge_mode_q    <= MODE_PLAIN;
			edge_left_q    <= '0;
			edge_right_q   <= IDX_W'(1023);
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_SOURCE_WIDTH: source_width_q <= cfg_wdata[WIDTH_W-1:0];
				REG_RESULT_WIDTH: result_width_q <= cfg_wdata[WIDTH_W-1:0];
				REG_EDGE_MODE:    edge_mode_q    <= cfg_wdata[MODE_W-1:0];
				REG_EDGE_LEFT:    edge_left_q    <= cfg_wdata[IDX_W-1:0];
				REG_EDGE_RIGHT:   edge_right_q   <= cfg_wdata[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	// Control state
	state_t            state_q, state_d;
	logic [RES_AW-1:0] clr_q;
	logic [IDX_W-1:0]  tgt_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  start_q;
	logic [CNT_W-1:0]  count_q;
	logic [TAP_W-1:0]  tap_q;

	// Decoded request
	logic       req_fire;
	logic       is_compute;
	logic [IDX_W-1:0] eff_idx;
	logic       edge_out;
	logic       range_out;
	logic       zero_result;
	logic       clear_done;
	logic       last_tap;

	// Controller outputs
	logic       req_ready;
	logic       hdr_rd_en;
	logic       tap_issue;
	logic       head_load;
	logic       out_load;

	assign req_fire   = req.valid && req_ready;
	assign is_compute = (req.operation == OP_COMPUTE);
	assign clear_done = (clr_q == RES_AW'(MAX_RESULT_WIDTH - 1));
	assign last_tap   = ((CNT_W'(tap_q) + CNT_W'(1)) == count_q);

	// Edge handling: zero flags targets outside the span, replicate maps onto the nearest end of the span
	always_comb begin
		eff_idx  = req.target_index;
		edge_out = 1'b0;
		case (edge_mode_t'(edge_mode_q))
			MODE_ZERO: begin
				edge_out = (req.target_index < edge_left_q) ||
				           (req.target_index > edge_right_q);
			end
			MODE_REPLICATE: begin
				if (req.target_index < edge_left_q) begin
					eff_idx = edge_left_q;
				end else if (req.target_index > edge_right_q) begin
					eff_idx = edge_right_q;
				end
			end
			default: ;
		endcase
	end

	assign range_out   = ({1'b0, eff_idx} >= result_width_q) ||
	                     (int'(eff_idx) >= MAX_RESULT_WIDTH);
	assign zero_result = edge_out || range_out;

	// Output register state (declared here, used by the controller)
	logic                      out_valid_q;
	logic [IDX_W-1:0]          out_index_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic                      out_sat_q;
	logic                      out_free;

	assign out_free = !out_valid_q || rsp.ready;

	// Pipeline tail flags
	logic v_s1, ok_s1, last_s1;
	logic v_s2, last_s2;
	logic signed [PROD_W-1:0] prod_s2;

	// Header read data, used by the controller
	hdr_t hdr_rdata;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_fire && is_compute) begin
					state_d = zero_result ? ST_ROUND : ST_HEAD;
				end
			end
			ST_HEAD: begin
				state_d = (hdr_rdata.count == '0) ? ST_ROUND : ST_TAPS;
			end
			ST_TAPS: begin
				if (last_tap) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (v_s2 && last_s2) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Controller outputs
	always_comb begin
		req_ready = 1'b0;
		hdr_rd_en = 1'b0;
		tap_issue = 1'b0;
		head_load = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE:  begin
				req_ready = 1'b1;
				hdr_rd_en = req.valid && is_compute && !zero_result;
			end
			ST_HEAD:  head_load = 1'b1;
			ST_TAPS:  tap_issue = 1'b1;
			ST_ROUND: out_load  = out_free;
			default: ;
		endcase
	end

	assign req.ready = req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + RES_AW'(1);
		end
	end

	// Hold the request context of a compute
	always_ff @(posedge clk) begin
		if (req_fire && is_compute) begin
			tgt_q <= req.target_index;
			idx_q <= eff_idx;
		end
		if (head_load) begin
			start_q <= hdr_rdata.start;
			count_q <= hdr_rdata.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (head_load) begin
			tap_q <= '0;
		end else if (tap_issue) begin
			tap_q <= tap_q + TAP_W'(1);
		end
	end

	// Header memory: start index and tap count per output pixel
	hdr_t              hdr_mem [MAX_RESULT_WIDTH];
	hdr_t              hdr_wdata;
	logic              hdr_we;
	logic [RES_AW-1:0] hdr_waddr;
	logic [CNT_W-1:0]  total_sat;

	assign total_sat = (int'(req.tap_total) > MAX_TAPS) ? CNT_W'(MAX_TAPS)
	                                                     : CNT_W'(req.tap_total);

	always_comb begin
		hdr_we    = 1'b0;
		hdr_waddr = RES_AW'(req.target_index);
		hdr_wdata = '{start: req.start_index, count: total_sat};
		if (state_q == ST_CLEAR) begin
			// Drop every tap count to zero
			hdr_we    = 1'b1;
			hdr_waddr = clr_q;
			hdr_wdata = '0;
		end else if (req_fire && req.operation == OP_HEADER) begin
			hdr_we = (int'(req.target_index) < MAX_RESULT_WIDTH);
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_we) hdr_mem[hdr_waddr] <= hdr_wdata;
		if (hdr_rd_en) hdr_rdata <= hdr_mem[RES_AW'(eff_idx)];
	end

	// Weight memory: MAX_TAPS weights per output pixel
	logic signed [WEIGHT_W-1:0] wt_mem [MAX_RESULT_WIDTH * MAX_TAPS];
	logic signed [WEIGHT_W-1:0] wt_rdata;
	logic                       wt_we;
	logic [WT_AW-1:0]           wt_waddr;
	logic [WT_AW-1:0]           wt_raddr;

	assign wt_we = req_fire && (req.operation == OP_WEIGHT) &&
	               (int'(req.target_index) < MAX_RESULT_WIDTH) &&
	               (int'(req.tap_slot) < MAX_TAPS);
	assign wt_waddr = WT_AW'(WT_AW'(req.target_index) * WT_AW'(MAX_TAPS)) +
	                  WT_AW'(req.tap_slot);
	assign wt_raddr = WT_AW'(WT_AW'(idx_q) * WT_AW'(MAX_TAPS)) + WT_AW'(tap_q);

	always_ff @(posedge clk) begin
		if (wt_we) wt_mem[wt_waddr] <= req.tap_weight;
		if (tap_issue) wt_rdata <= wt_mem[wt_raddr];
	end

	// Row memory: source pixels
	logic signed [PIXEL_W-1:0] row_mem [MAX_SOURCE_WIDTH];
	logic signed [PIXEL_W-1:0] row_rdata;
	logic                      row_we;
	logic [SRC_W-1:0]          src_idx;
	logic                      src_ok;

	assign row_we  = req_fire && (req.operation == OP_PIXEL) &&
	                 (int'(req.pixel_index) < MAX_SOURCE_WIDTH);
	assign src_idx = SRC_W'(start_q) + SRC_W'(tap_q);
	// Taps past the row contribute nothing
	assign src_ok  = (src_idx < SRC_W'(source_width_q)) &&
	                 (int'(src_idx) < MAX_SOURCE_WIDTH);

	always_ff @(posedge clk) begin
		if (row_we) row_mem[ROW_AW'(req.pixel_index)] <= req.pixel_value;
		if (tap_issue) row_rdata <= row_mem[ROW_AW'(src_idx)];
	end

	// Multiply-accumulate: read data in s1, product in s2, then accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			ok_s1   <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v_s1    <= tap_issue;
			last_s1 <= tap_issue && last_tap;
			ok_s1   <= src_ok;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= ok_s1 ? PROD_W'(row_rdata * wt_rdata) : '0;
	end

	logic signed [ACC_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (req_fire && is_compute) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Round half up, floor shift, saturate to 32 bits
	localparam logic signed [63:0] VAL_MAX = 64'sd2147483647;
	localparam logic signed [63:0] VAL_MIN = -64'sd2147483648;

	logic [ACC_W:0]          rnd;
	logic signed [Q_W-1:0]   q;
	logic signed [63:0]      q_ext;
	logic signed [VALUE_W-1:0] res_value;
	logic                    res_sat;

	assign rnd   = (ACC_W+1)'(acc_q) + (ACC_W+1)'(1 << (FRAC_W - 1));
	assign q     = rnd[ACC_W:FRAC_W];
	assign q_ext = 64'(q);

	always_comb begin
		res_sat   = 1'b0;
		res_value = q_ext[VALUE_W-1:0];
		if (q_ext > VAL_MAX) begin
			res_sat   = 1'b1;
			res_value = VAL_MAX[VALUE_W-1:0];
		end else if (q_ext < VAL_MIN) begin
			res_sat   = 1'b1;
			res_value = VAL_MIN[VALUE_W-1:0];
		end
	end

	// Output register: holds a result until the sink takes the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_index_q <= tgt_q;
			out_value_q <= res_value;
			out_sat_q   <= res_sat;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_index = out_index_q;
	assign rsp.result_value = out_value_q;
	assign rsp.saturated    = out_sat_q;

endmodule
